@@ rtl/lsh_pkg.sv @@
// package: types, constants and tables for the lsh-256 hash core
`timescale 1ns / 1ps
package lsh_pkg;

  localparam int NumSteps = 26;
  localparam int BlockWords = 32;
  localparam int CvWords = 16;
  localparam int StepW = $clog2(NumSteps + 1);
  localparam logic [31:0] PadByte = 32'h0000_0080;

  typedef logic [31:0] word_t;
  typedef word_t [CvWords-1:0] cv_t;
  typedef word_t [BlockWords-1:0] blk_t;

  // a finished block handed from the front part to the compression part
  typedef struct packed {
    blk_t blk;
    logic fin;
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_FIN,
    S_OUT
  } cmp_state_t;

  function automatic cv_t iv_words();
    cv_t v;
    v[0] = 32'h46a10f1f; v[1] = 32'hfddce486; v[2] = 32'hb41443a8; v[3] = 32'h198e6b9d;
    v[4] = 32'h3304388d; v[5] = 32'hb0f5a3c7; v[6] = 32'hb36061c4; v[7] = 32'h7adbd553;
    v[8] = 32'h105d5378; v[9] = 32'h2f74de54; v[10] = 32'h5c2f2d95; v[11] = 32'hf2553fbe;
    v[12] = 32'h8051357a; v[13] = 32'h138668c8; v[14] = 32'h47aa4484; v[15] = 32'he01afb41;
    return v;
  endfunction

  localparam logic [31:0] StepConst [0:207] = '{
    32'h917caf90, 32'h6c1b10a2, 32'h6f352943, 32'hcf778243, 32'h2ceb7472, 32'h29e96ff2,
    32'h8a9ba428, 32'h2eeb2642, 32'h0e2c4021, 32'h872bb30e, 32'ha45e6cb2, 32'h46f9c612,
    32'h185fe69e, 32'h1359621b, 32'h263fccb2, 32'h1a116870, 32'h3a6c612f, 32'hb2dec195,
    32'h02cb1f56, 32'h40bfd858, 32'h784684b6, 32'h6cbb7d2e, 32'h660c7ed8, 32'h2b79d88a,
    32'ha6cd9069, 32'h91a05747, 32'hcdea7558, 32'h00983098, 32'hbecb3b2e, 32'h2838ab9a,
    32'h728b573e, 32'ha55262b5, 32'h745dfa0f, 32'h31f79ed8, 32'hb85fce25, 32'h98c8c898,
    32'h8a0669ec, 32'h60e445c2, 32'hfde295b0, 32'hf7b5185a, 32'hd2580983, 32'h29967709,
    32'h182df3dd, 32'h61916130, 32'h90705676, 32'h452a0822, 32'he07846ad, 32'haccd7351,
    32'h2a618d55, 32'hc00d8032, 32'h4621d0f5, 32'hf2f29191, 32'h00c6cd06, 32'h6f322a67,
    32'h58bef48d, 32'h7a40c4fd, 32'h8beee27f, 32'hcd8db2f2, 32'h67f2c63b, 32'he5842383,
    32'hc793d306, 32'ha15c91d6, 32'h17b381e5, 32'hbb05c277, 32'h7ad1620a, 32'h5b40a5bf,
    32'h5ab901a2, 32'h69a7a768, 32'h5b66d9cd, 32'hfdee6877, 32'hcb3566fc, 32'hc0c83a32,
    32'h4c336c84, 32'h9be6651a, 32'h13baa3fc, 32'h114f0fd1, 32'hc240a728, 32'hec56e074,
    32'h009c63c7, 32'h89026cf2, 32'h7f9ff0d0, 32'h824b7fb5, 32'hce5ea00f, 32'h605ee0e2,
    32'h02e7cfea, 32'h43375560, 32'h9d002ac7, 32'h8b6f5f7b, 32'h1f90c14f, 32'hcdcb3537,
    32'h2cfeafdd, 32'hbf3fc342, 32'heab7b9ec, 32'h7a8cb5a3, 32'h9d2af264, 32'hfacedb06,
    32'hb052106e, 32'h99006d04, 32'h2bae8d09, 32'hff030601, 32'ha271a6d6, 32'h0742591d,
    32'hc81d5701, 32'hc9a9e200, 32'h02627f1e, 32'h996d719d, 32'hda3b9634, 32'h02090800,
    32'h14187d78, 32'h499b7624, 32'he57458c9, 32'h738be2c9, 32'h64e19d20, 32'h06df0f36,
    32'h15d1cb0e, 32'h0b110802, 32'h2c95f58c, 32'he5119a6d, 32'h59cd22ae, 32'hff6eac3c,
    32'h467ebd84, 32'he5ee453c, 32'he79cd923, 32'h1c190a0d, 32'hc28b81b8, 32'hf6ac0852,
    32'h26efd107, 32'h6e1ae93b, 32'hc53c41ca, 32'hd4338221, 32'h8475fd0a, 32'h35231729,
    32'h4e0d3a7a, 32'ha2b45b48, 32'h16c0d82d, 32'h890424a9, 32'h017e0c8f, 32'h07b5a3f5,
    32'hfa73078e, 32'h583a405e, 32'h5b47b4c8, 32'h570fa3ea, 32'hd7990543, 32'h8d28ce32,
    32'h7f8a9b90, 32'hbd5998fc, 32'h6d7a9688, 32'h927a9eb6, 32'ha2fc7d23, 32'h66b38e41,
    32'h709e491a, 32'hb5f700bf, 32'h0a262c0f, 32'h16f295b9, 32'he8111ef5, 32'h0d195548,
    32'h9f79a0c5, 32'h1a41cfa7, 32'h0ee7638a, 32'hacf7c074, 32'h30523b19, 32'h09884ecf,
    32'hf93014dd, 32'h266e9d55, 32'h191a6664, 32'h5c1176c1, 32'hf64aed98, 32'ha4b83520,
    32'h828d5449, 32'h91d71dd8, 32'h2944f2d6, 32'h950bf27b, 32'h3380ca7d, 32'h6d88381d,
    32'h4138868e, 32'h5ced55c4, 32'h0fe19dcb, 32'h68f4f669, 32'h6e37c8ff, 32'ha0fe6e10,
    32'hb44b47b0, 32'hf5c0558a, 32'h79bf14cf, 32'h4a431a20, 32'hf17f68da, 32'h5deb5fd1,
    32'ha600c86d, 32'h9f6c7eb0, 32'hff92f864, 32'hb615e07f, 32'h38d3e448, 32'h8d5d3a6a,
    32'h70e843cb, 32'h494b312e, 32'ha6c93613, 32'h0beb2f4f, 32'h928b5d63, 32'hcbf66035,
    32'h0cb82c80, 32'hea97a4f7, 32'h592c0f3b, 32'h947c5f77, 32'h6fff49b9, 32'hf71a7e5a,
    32'h1de8c0f5, 32'hc2569600, 32'hc4e4ac8c, 32'h823c9ce1
  };

  localparam int GammaRot [0:7] = '{0, 8, 16, 24, 24, 16, 8, 0};
  localparam int TauSel [0:15] = '{3, 2, 0, 1, 7, 4, 5, 6, 11, 10, 8, 9, 15, 12, 13, 14};
  localparam int SigmaSel [0:15] = '{6, 4, 5, 7, 12, 15, 14, 13, 2, 0, 1, 3, 8, 11, 10, 9};

  // fixed rotations, a zero amount passes the word through
  function automatic word_t rotl(input word_t v, input int r);
    word_t res;
    res = v;
    if ((r % 32) != 0) begin
      res = (v << (r % 32)) | (v >> (32 - (r % 32)));
    end
    return res;
  endfunction

endpackage

@@ rtl/lsh_if.sv @@
// interfaces: valid/ready stream channels for input words and digest words
`timescale 1ns / 1ps
interface lsh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface lsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_of_digest;
  modport source (output valid, digest_word, word_index, last_of_digest, input ready);
  modport sink (input valid, digest_word, word_index, last_of_digest, output ready);
endinterface

@@ rtl/lsh_front.sv @@
// front part: gathers words into blocks, pads the final block
`timescale 1ns / 1ps
module lsh_front (
  input  logic           clk,
  input  logic           rst_n,
  lsh_in_if.sink         in_ch,
  output logic           job_valid,
  input  logic           job_ready,
  output lsh_pkg::job_t  job
);
  lsh_pkg::blk_t blk_r, blk_nxt;
  logic [4:0]    widx_r, widx_nxt;
  // pending pad block after a last word that closed a full block
  logic          pad_r, pad_nxt;
  logic          jv_r, jv_nxt;
  logic          fin_r, fin_nxt;
  logic [31:0]   mask;
  logic [31:0]   padw;
  logic [2:0]    nb;

  assign job_valid = jv_r;
  assign job.blk   = blk_r;
  assign job.fin   = fin_r;
  assign in_ch.ready = !jv_r && !pad_r;

  always_comb begin
    nb = (in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
    unique case (nb)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    padw = (in_ch.message_word & mask) | (lsh_pkg::PadByte << {nb[1:0], 3'b000});
  end

  always_comb begin
    blk_nxt  = blk_r;
    widx_nxt = widx_r;
    pad_nxt  = pad_r;
    jv_nxt   = jv_r;
    fin_nxt  = fin_r;
    if (jv_r && job_ready) begin
      jv_nxt = 1'b0;
    end
    if (pad_r && !jv_r) begin
      // fresh block holding only the pad byte
      blk_nxt     = '0;
      blk_nxt[0]  = lsh_pkg::PadByte;
      pad_nxt     = 1'b0;
      jv_nxt      = 1'b1;
      fin_nxt     = 1'b1;
    end else if (in_ch.valid && in_ch.ready) begin
      if (!in_ch.last_word || nb == 3'd4) begin
        blk_nxt[widx_r] = in_ch.message_word;
        if (in_ch.last_word) begin
          for (int i = 0; i < lsh_pkg::BlockWords; i++) begin
            if (i > widx_r) blk_nxt[i] = (i == widx_r + 1) ? lsh_pkg::PadByte : '0;
          end
          if (widx_r == 5'd31) begin
            pad_nxt = 1'b1;
            fin_nxt = 1'b0;
          end else begin
            fin_nxt = 1'b1;
          end
          jv_nxt   = 1'b1;
          widx_nxt = '0;
        end else begin
          widx_nxt = widx_r + 5'd1;
          if (widx_r == 5'd31) begin
            jv_nxt  = 1'b1;
            fin_nxt = 1'b0;
          end
        end
      end else begin
        blk_nxt[widx_r] = padw;
        for (int i = 0; i < lsh_pkg::BlockWords; i++) begin
          if (i > widx_r) blk_nxt[i] = '0;
        end
        jv_nxt   = 1'b1;
        fin_nxt  = 1'b1;
        widx_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (!rst_n) begin
      widx_r <= '0;
      pad_r  <= 1'b0;
      jv_r   <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      widx_r <= widx_nxt;
      pad_r  <= pad_nxt;
      jv_r   <= jv_nxt;
      fin_r  <= fin_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pad_final: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r && !jv_r |=> jv_r && fin_r) else $error("pad block not issued");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    jv_r |-> !in_ch.ready) else $error("input taken while job pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    jv_r && !job_ready |=> jv_r && $stable(fin_r)) else $error("job dropped");
`endif
endmodule

@@ rtl/lsh_compress.sv @@
// back part: block queue, message expansion, mix steps and digest output
`timescale 1ns / 1ps
module lsh_compress (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  lsh_pkg::job_t  job,
  lsh_out_if.source      out_ch
);
  // one-entry queue between front and back
  lsh_pkg::job_t     q_r;
  logic              qv_r;
  lsh_pkg::cmp_state_t st_r, st_nxt;
  lsh_pkg::cv_t      cv_r, cv_nxt;
  lsh_pkg::word_t [31:0] win_r, win_nxt;
  logic [lsh_pkg::StepW-1:0] step_r, step_nxt;
  logic              fin_r, fin_nxt;
  logic [2:0]        oidx_r, oidx_nxt;
  logic              take;
  lsh_pkg::cv_t      tmp;
  lsh_pkg::word_t    l, r, cst;

  assign job_ready = !qv_r;
  assign take = qv_r && st_r == lsh_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) q_r <= job;
    if (!rst_n) qv_r <= 1'b0;
    else if (job_valid && job_ready) qv_r <= 1'b1;
    else if (take) qv_r <= 1'b0;
  end

  always_comb begin
    tmp = '0;
    l = '0;
    r = '0;
    cst = '0;
    for (int c = 0; c < 8; c++) begin
      l = cv_r[c] ^ win_r[c];
      r = cv_r[c+8] ^ win_r[c+8];
      cst = lsh_pkg::StepConst[{step_r, 3'b000} + 8'(c)];
      if (step_r[0]) begin
        l = lsh_pkg::rotl(l + r, 5) ^ cst;
        r = lsh_pkg::rotl(l + r, 17);
      end else begin
        l = lsh_pkg::rotl(l + r, 29) ^ cst;
        r = lsh_pkg::rotl(l + r, 1);
      end
      tmp[c]   = l + r;
      tmp[c+8] = lsh_pkg::rotl(r, lsh_pkg::GammaRot[c]);
    end
  end

  always_comb begin
    st_nxt   = st_r;
    cv_nxt   = cv_r;
    win_nxt  = win_r;
    step_nxt = step_r;
    fin_nxt  = fin_r;
    oidx_nxt = oidx_r;
    out_ch.valid          = 1'b0;
    out_ch.digest_word    = cv_r[oidx_r] ^ cv_r[{1'b1, oidx_r}];
    out_ch.word_index     = oidx_r;
    out_ch.last_of_digest = (oidx_r == 3'd7);
    unique case (st_r)
      lsh_pkg::S_IDLE: begin
        if (take) begin
          win_nxt  = q_r.blk;
          fin_nxt  = q_r.fin;
          step_nxt = '0;
          st_nxt   = lsh_pkg::S_MIX;
        end
      end
      lsh_pkg::S_MIX: begin
        for (int k = 0; k < 16; k++) begin
          cv_nxt[k]      = tmp[lsh_pkg::SigmaSel[k]];
          win_nxt[k]     = win_r[16+k];
          win_nxt[16+k]  = win_r[16+k] + win_r[lsh_pkg::TauSel[k]];
        end
        step_nxt = step_r + 1'b1;
        if (step_r == lsh_pkg::StepW'(lsh_pkg::NumSteps - 1)) st_nxt = lsh_pkg::S_FIN;
      end
      lsh_pkg::S_FIN: begin
        for (int k = 0; k < 16; k++) cv_nxt[k] = cv_r[k] ^ win_r[k];
        oidx_nxt = '0;
        st_nxt = fin_r ? lsh_pkg::S_OUT : lsh_pkg::S_IDLE;
      end
      lsh_pkg::S_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cv_nxt = lsh_pkg::iv_words();
            st_nxt = lsh_pkg::S_IDLE;
          end
        end
      end
      default: st_nxt = lsh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    fin_r  <= fin_nxt;
    if (!rst_n) begin
      st_r   <= lsh_pkg::S_IDLE;
      cv_r   <= lsh_pkg::iv_words();
      step_r <= '0;
      oidx_r <= '0;
    end else begin
      st_r   <= st_nxt;
      cv_r   <= cv_nxt;
      step_r <= step_nxt;
      oidx_r <= oidx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == lsh_pkg::S_MIX |-> step_r < lsh_pkg::StepW'(lsh_pkg::NumSteps))
    else $error("step count overrun");
  a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> st_r == lsh_pkg::S_OUT) else $error("stray output");
  a_iv: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_of_digest |=> cv_r == lsh_pkg::iv_words())
    else $error("chain value not reset");
`endif
endmodule

@@ rtl/lsh256_hash_core.sv @@
// top level: lsh-256-256 hash core
//  channel | dir | handshake           | payload
//  in_ch   | in  | valid/ready         | message_word, valid_bytes, last_word
//  out_ch  | out | valid/ready         | digest_word, word_index, last_of_digest
// one input word per cycle while no finished or pad block waits; a full block
// holds the input until it passes into the queue; compression runs take, 26 mix
// steps and finalize, and keeps up; the first digest word follows the last word
// through the job register, the queue and compression, then 8 transfers;
// a stalled result side backs up the queue and then the input
// a last word that closes a full block costs a second pad block
// reset is synchronous, active low; the iv is loaded at once
`timescale 1ns / 1ps
module lsh256_hash_core (
  input logic        clk,
  input logic        rst_n,
  lsh_in_if.sink     in_ch,
  lsh_out_if.source  out_ch
);
  logic          job_valid;
  logic          job_ready;
  lsh_pkg::job_t job;

  lsh_front u_front (
    .clk, .rst_n, .in_ch, .job_valid, .job_ready, .job
  );

  lsh_compress u_compress (
    .clk, .rst_n, .job_valid, .job_ready, .job, .out_ch
  );
endmodule

@@ verif/tb_lsh256_hash_core.sv @@
// testbench for the lsh-256-256 hash core: scoreboard with a hash predictor, random traffic
`timescale 1ns / 1ps

class digest_scoreboard;
  logic [31:0] cv [16];
  logic [31:0] blk [32];
  int unsigned fill;
  logic [31:0] exp_word [$];
  logic [2:0]  exp_idx [$];
  logic        exp_last [$];

  function new();
    restart();
  endfunction

  function void restart();
    lsh_pkg::cv_t v;
    v = lsh_pkg::iv_words();
    for (int i = 0; i < 16; i++) cv[i] = v[i];
    fill = 0;
  endfunction

  function logic [31:0] rol(logic [31:0] v, int r);
    r = r % 32;
    if (r == 0) return v;
    return (v << r) | (v >> (32 - r));
  endfunction

  function void compress();
    logic [31:0] mw [32];
    logic [31:0] tmp [16];
    logic [31:0] nxt [16];
    logic [31:0] l, r;
    int a, b;
    for (int i = 0; i < 32; i++) mw[i] = blk[i];
    for (int j = 0; j < lsh_pkg::NumSteps; j++) begin
      a = (j % 2) ? 5 : 29;
      b = (j % 2) ? 17 : 1;
      for (int c = 0; c < 8; c++) begin
        l = cv[c] ^ mw[c];
        r = cv[c + 8] ^ mw[c + 8];
        l = rol(l + r, a) ^ lsh_pkg::StepConst[(8 * j + c) % 208];
        r = rol(l + r, b);
        tmp[c] = l + r;
        tmp[c + 8] = rol(r, lsh_pkg::GammaRot[c]);
      end
      for (int c = 0; c < 16; c++) cv[c] = tmp[lsh_pkg::SigmaSel[c]];
      for (int c = 0; c < 16; c++) nxt[c] = mw[16 + c] + mw[lsh_pkg::TauSel[c]];
      for (int c = 0; c < 16; c++) begin
        mw[c] = mw[16 + c];
        mw[16 + c] = nxt[c];
      end
    end
    for (int c = 0; c < 16; c++) cv[c] ^= mw[c];
  endfunction

  function void push_word(logic [31:0] w);
    blk[fill] = w;
    fill = (fill + 1) % 32;
    if (fill == 0) compress();
  endfunction

  function void note_input(logic [31:0] w, logic [2:0] nb, logic last);
    int n;
    logic [31:0] mask;
    if (!last) begin
      push_word(w);
      return;
    end
    n = (nb > 3'd4) ? 4 : int'(nb);
    if (n == 4) begin
      push_word(w);
      blk[fill] = lsh_pkg::PadByte;
    end else begin
      mask = (n == 0) ? 32'h0 : ((32'h1 << (8 * n)) - 32'h1);
      blk[fill] = (w & mask) | (lsh_pkg::PadByte << (8 * n));
    end
    for (int i = fill + 1; i < 32; i++) blk[i] = '0;
    compress();
    for (int i = 0; i < 8; i++) begin
      exp_word.push_back(cv[i] ^ cv[i + 8]);
      exp_idx.push_back(i[2:0]);
      exp_last.push_back(i == 7);
    end
    restart();
  endfunction

  function int pending();
    return exp_word.size();
  endfunction
endclass

module tb_lsh256_hash_core;
  logic clk;
  logic rst_n;
  int unsigned fails;
  int unsigned idle_cycles;

  lsh_in_if in_ch ();
  lsh_out_if out_ch ();
  digest_scoreboard sb;

  lsh256_hash_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // valid stays up after a transfer until the next word or a drain
  task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic last);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.message_word <= w;
    in_ch.valid_bytes <= nb;
    in_ch.last_word <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(w, nb, last);
  endtask

  // whole-word body followed by a last word
  task automatic send_message(input int words, input logic [2:0] nb);
    for (int i = 0; i < words; i++) send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom, nb, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // result side: random stalls, check each transfer
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (sb.pending() == 0) begin
        report("unexpected digest word", out_ch.digest_word, 32'h0);
      end else begin
        if (out_ch.digest_word !== sb.exp_word[0])
          report("digest_word", out_ch.digest_word, sb.exp_word[0]);
        if (out_ch.word_index !== sb.exp_idx[0])
          report("word_index", {29'h0, out_ch.word_index}, {29'h0, sb.exp_idx[0]});
        if (out_ch.last_of_digest !== sb.exp_last[0])
          report("last_of_digest", {31'h0, out_ch.last_of_digest}, {31'h0, sb.exp_last[0]});
        void'(sb.exp_word.pop_front());
        void'(sb.exp_idx.pop_front());
        void'(sb.exp_last.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int count;
    int len;
    sb = new();
    fails = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.message_word = '0;
    in_ch.valid_bytes = '0;
    in_ch.last_word = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, extremes, each byte count, block-closing last word
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'h00000000, 3'd2, 1'b1);
    send_word(32'ha5a5a5a5, 3'd3, 1'b1);
    send_word(32'h5a5a5a5a, 3'd7, 1'b1);
    send_message(31, 3'd4);
    send_message(31, 3'd3);
    send_message(32, 3'd0);
    // hold off until every digest has come back
    drain();

    count = 0;
    while (count < 300) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(28, 70);
      else len = $urandom_range(0, 12);
      send_message(len, 3'($urandom_range(0, 7)));
      count += len + 1;
    end
    drain();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ lsh256_hash_core.f @@
rtl/lsh_pkg.sv
rtl/lsh_if.sv
rtl/lsh_front.sv
rtl/lsh_compress.sv
rtl/lsh256_hash_core.sv
verif/tb_lsh256_hash_core.sv
